// ===== sv/hvn_pkg.sv =====
package hvn_pkg;

   // Sizes
   localparam int MAX_WIDTH        = 1024;
   localparam int MAX_ROWS         = 1024;
   localparam int HEIGHT_BITS      = 16;
   localparam int NORMAL_FRAC_BITS = 14;

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int POS_W  = ($clog2(MAX_WIDTH) + 1 > 11) ? $clog2(MAX_WIDTH) + 1 : 11;

   // Arithmetic widths
   localparam int CMP_W      = 18;              // vector component, signed
   localparam int MUL_W      = 19;              // multiplier operand, signed
   localparam int PROD_W     = 2 * MUL_W;
   localparam int SUM_W      = 36;              // squared length
   localparam int RAD_W      = 60;              // root radicand
   localparam int ROOT_W     = RAD_W / 2;
   localparam int ROOT_STEPS = RAD_W / 2;
   localparam int DIV_W      = 48;
   localparam int DIV_STEPS  = NORMAL_FRAC_BITS + 1;
   localparam int FACE_SHIFT = 24;
   localparam int VERT_SHIFT = 20;
   localparam int COUNT_W    = $clog2(ROOT_STEPS > DIV_STEPS ? ROOT_STEPS : DIV_STEPS);

   localparam logic [15:0] UNIT_ONE = 16'(1 << NORMAL_FRAC_BITS);
   localparam logic signed [CMP_W-1:0] FACE_UP = CMP_W'(64);

   // CSR map
   localparam int CSR_AW    = 4;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 2'd2;

   localparam logic [15:0] GAIN_RESET   = 16'd256;
   localparam logic [10:0] WIDTH_RESET  = 11'd257;
   localparam logic [10:0] HEIGHT_RESET = 11'd257;

   // Request opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } face_type;

   typedef struct packed {
      logic signed [CMP_W-1:0] x;
      logic signed [CMP_W-1:0] y;
      logic signed [CMP_W-1:0] z;
   } vec_type;

   typedef enum logic [1:0] {
      PH_FACE,
      PH_VERT1,
      PH_VERT2,
      PH_FLUSH
   } phase_type;

   typedef enum logic [4:0] {
      DP_NONE,
      DP_LOAD,
      DP_SCALE_MUL,
      DP_SCALE_WR,
      DP_FACE_SET,
      DP_VSUM1,
      DP_VSUM2,
      DP_FL_RD0,
      DP_FL_RD1,
      DP_FL_SUM,
      DP_SQ_MUL,
      DP_SQ_LAST,
      DP_ZERO_NORM,
      DP_ROOT_STEP,
      DP_DIV_PRE,
      DP_DIV_CHK,
      DP_DIV_STEP,
      DP_DIV_END,
      DP_EMIT,
      DP_ADVANCE,
      DP_FL_ADV
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] comp;
      phase_type  phase;
   } dp_cmd_type;

   typedef struct packed {
      logic is_flush;
      logic sample_ok;
      logic flush_ok;
      logic has_face;
      logic row_end;
      logic sum_zero;
   } dp_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCALE_MUL,
      ST_SCALE_WR,
      ST_FACE_SET,
      ST_SQ,
      ST_SQ_LAST,
      ST_SUM_CHK,
      ST_ROOT,
      ST_DIV_PRE,
      ST_DIV_CHK,
      ST_DIV_STEP,
      ST_DIV_END,
      ST_NORM_DONE,
      ST_VSUM1,
      ST_VSUM2,
      ST_EMIT,
      ST_ADVANCE,
      ST_FL_RD0,
      ST_FL_RD1,
      ST_FL_SUM,
      ST_FL_ADV
   } state_type;

endpackage

// ===== sv/hvn_ram.sv =====
module hvn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/hvn_datapath.sv =====
module hvn_datapath
   import hvn_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_op,
   input  logic [15:0]             req_height,
   input  logic                    cfg_we,
   input  logic [CSR_IDX_W-1:0]    cfg_idx,
   input  logic [31:0]             cfg_data,
   input  logic [CSR_IDX_W-1:0]    rd_idx,
   output logic [31:0]             rd_data,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   output logic signed [15:0]      normal_x,
   output logic signed [15:0]      normal_y,
   output logic signed [15:0]      normal_z,
   output logic [9:0]              vertex_col,
   output logic [9:0]              vertex_row,
   output logic                    last_of_run,
   output logic                    frame_done
);

   // config and position
   logic [15:0]      gain_ff, gain_in;
   logic [10:0]      width_ff, width_in;
   logic [10:0]      height_ff, height_in;
   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [POS_W-1:0] flush_ff, flush_in;

   // request and scaling
   logic                   op_ff, op_in;
   logic [HEIGHT_BITS-1:0] raw_ff, raw_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [15:0]            prev_h_ff, prev_h_in;
   logic [15:0]            bl_ff, bl_in;
   logic [15:0]            br_ff, br_in;
   logic [15:0]            ul_ff, ul_in;

   // normalisation
   vec_type               vec_ff, vec_in;
   logic                  is_face_ff, is_face_in;
   logic [SUM_W-1:0]      acc_ff, acc_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [RAD_W-1:0]      res_ff, res_in;
   logic [RAD_W-1:0]      bit_ff, bit_in;
   logic [DIV_W-1:0]      num_ff, num_in;
   logic [DIV_W-1:0]      den_ff, den_in;
   logic [DIV_STEPS-1:0]  q_ff, q_in;
   logic                  sat_ff, sat_in;
   face_type              nrm_ff, nrm_in;

   // face normals held for the running sums
   face_type cur_ff, cur_in;
   face_type above_ff, above_in;
   face_type left0_ff, left0_in;
   face_type left1_ff, left1_in;

   // result register
   face_type   out_ff, out_in;
   logic [9:0] out_col_ff, out_col_in;
   logic [9:0] out_row_ff, out_row_in;
   logic       out_last_ff, out_last_in;
   logic       out_done_ff, out_done_in;

   // memories
   logic [ADDR_W:0]   hram_waddr, hram_raddr;
   logic [15:0]       hram_rdata;
   logic              hram_we;
   logic [ADDR_W-1:0] fram_waddr, fram_raddr;
   logic [47:0]       fram_rdata;
   logic              fram_we;
   face_type          fram_face;

   logic [POS_W-1:0] eff_w, eff_h, w_m1, h_m1, col_m1, row_m1;
   logic             c_ge2, r_ge2;

   hvn_ram #(.WIDTH(16), .DEPTH(2 * MAX_WIDTH)) u_height_ram (
      .clock (clock),
      .we    (hram_we),
      .waddr (hram_waddr),
      .wdata (br_in),
      .raddr (hram_raddr),
      .rdata (hram_rdata)
   );

   hvn_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_face_ram (
      .clock (clock),
      .we    (fram_we),
      .waddr (fram_waddr),
      .wdata (cur_ff),
      .raddr (fram_raddr),
      .rdata (fram_rdata)
   );

   assign fram_face = face_type'(fram_rdata);

   function automatic vec_type vadd(vec_type a, face_type f, logic en);
      vec_type r;
      r = a;
      if (en) begin
         r.x = a.x + CMP_W'(f.x);
         r.y = a.y + CMP_W'(f.y);
         r.z = a.z + CMP_W'(f.z);
      end
      return r;
   endfunction

   // effective grid size
   always_comb begin
      if (width_ff < 11'd2) begin
         eff_w = POS_W'(2);
      end else if (POS_W'(width_ff) > POS_W'(MAX_WIDTH)) begin
         eff_w = POS_W'(MAX_WIDTH);
      end else begin
         eff_w = POS_W'(width_ff);
      end
      if (height_ff < 11'd2) begin
         eff_h = POS_W'(2);
      end else if (POS_W'(height_ff) > POS_W'(MAX_ROWS)) begin
         eff_h = POS_W'(MAX_ROWS);
      end else begin
         eff_h = POS_W'(height_ff);
      end
   end

   assign w_m1   = eff_w - POS_W'(1);
   assign h_m1   = eff_h - POS_W'(1);
   assign col_m1 = col_ff - POS_W'(1);
   assign row_m1 = row_ff - POS_W'(1);
   assign c_ge2  = col_ff >= POS_W'(2);
   assign r_ge2  = row_ff >= POS_W'(2);

   always_comb begin
      status.is_flush  = (op_ff == OP_FLUSH);
      status.sample_ok = (row_ff < eff_h) && (col_ff < eff_w);
      status.flush_ok  = (row_ff >= eff_h) && (flush_ff < eff_w);
      status.has_face  = (row_ff != '0) && (col_ff != '0);
      status.row_end   = (col_ff == w_m1);
      status.sum_zero  = (sum_ff == '0);
   end

   // memory addressing
   always_comb begin
      hram_raddr = {~row_ff[0], col_m1[ADDR_W-1:0]};
      hram_waddr = {row_ff[0], col_ff[ADDR_W-1:0]};
      hram_we    = (cmd.op == DP_SCALE_WR);
      fram_we    = (cmd.op == DP_ADVANCE) && status.has_face;
      fram_waddr = col_m1[ADDR_W-1:0];
      case (cmd.op)
         DP_SCALE_MUL: fram_raddr = col_m1[ADDR_W-1:0];
         DP_FL_RD0:    fram_raddr = ADDR_W'(flush_ff - POS_W'(1));
         default:      fram_raddr = flush_ff[ADDR_W-1:0];
      endcase
   end

   // main datapath
   always_comb begin
      logic signed [CMP_W-1:0] cv;
      logic [CMP_W-1:0]        mag;
      logic signed [MUL_W-1:0] mul_a;
      logic signed [MUL_W-1:0] mul_b;
      logic [32:0]             scaled_sum;
      logic [SUM_W-1:0]        total;
      logic [RAD_W-1:0]        trial;
      logic [DIV_W-1:0]        mag_w;
      logic [DIV_STEPS-1:0]    qv;
      logic [15:0]             qmag;
      vec_type                 vs;

      gain_in     = gain_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      flush_in    = flush_ff;
      op_in       = op_ff;
      raw_in      = raw_ff;
      prod_in     = prod_ff;
      prev_h_in   = prev_h_ff;
      bl_in       = bl_ff;
      br_in       = br_ff;
      ul_in       = ul_ff;
      vec_in      = vec_ff;
      is_face_in  = is_face_ff;
      acc_in      = acc_ff;
      sum_in      = sum_ff;
      rad_in      = rad_ff;
      res_in      = res_ff;
      bit_in      = bit_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      q_in        = q_ff;
      sat_in      = sat_ff;
      nrm_in      = nrm_ff;
      cur_in      = cur_ff;
      above_in    = above_ff;
      left0_in    = left0_ff;
      left1_in    = left1_ff;
      out_in      = out_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_last_in = out_last_ff;
      out_done_in = out_done_ff;

      case (cmd.comp)
         2'd0:    cv = vec_ff.x;
         2'd1:    cv = vec_ff.y;
         default: cv = vec_ff.z;
      endcase
      mag = cv[CMP_W-1] ? CMP_W'(-cv) : CMP_W'(cv);

      if (cmd.op == DP_SCALE_MUL) begin
         mul_a = MUL_W'({1'b0, raw_ff});
         mul_b = MUL_W'({1'b0, gain_ff});
      end else begin
         mul_a = MUL_W'(cv);
         mul_b = MUL_W'(cv);
      end

      scaled_sum = {1'b0, prod_ff[31:0]} + 33'd2;
      total      = acc_ff + SUM_W'(prod_ff);
      trial      = res_ff + bit_ff;
      mag_w      = DIV_W'(mag);
      qv         = q_ff;
      qmag       = 16'(q_ff);
      vs         = '0;

      case (cmd.op)
         DP_LOAD: begin
            op_in  = req_op;
            raw_in = req_height[HEIGHT_BITS-1:0];
         end
         DP_SCALE_MUL: begin
            prod_in = mul_a * mul_b;
         end
         DP_SCALE_WR: begin
            if (scaled_sum[32:2] > 31'h0000_FFFF) begin
               br_in = 16'hFFFF;
            end else begin
               br_in = scaled_sum[17:2];
            end
            bl_in     = prev_h_ff;
            prev_h_in = br_in;
            ul_in     = hram_rdata;
            above_in  = fram_face;
         end
         DP_FACE_SET: begin
            vec_in.x   = CMP_W'({2'b00, bl_ff}) - CMP_W'({2'b00, br_ff});
            vec_in.y   = FACE_UP;
            vec_in.z   = CMP_W'({2'b00, bl_ff}) - CMP_W'({2'b00, ul_ff});
            is_face_in = 1'b1;
         end
         DP_VSUM1: begin
            cur_in     = nrm_ff;
            vs         = vadd('0, nrm_ff, 1'b1);
            vs         = vadd(vs, left0_ff, c_ge2);
            vs         = vadd(vs, above_ff, r_ge2);
            vec_in     = vadd(vs, left1_ff, c_ge2 && r_ge2);
            is_face_in = 1'b0;
         end
         DP_VSUM2: begin
            vs         = vadd('0, cur_ff, 1'b1);
            vec_in     = vadd(vs, above_ff, r_ge2);
            is_face_in = 1'b0;
         end
         DP_FL_RD1: begin
            above_in = fram_face;
         end
         DP_FL_SUM: begin
            vs         = vadd('0, above_ff, flush_ff != '0);
            vec_in     = vadd(vs, fram_face, flush_ff < w_m1);
            is_face_in = 1'b0;
         end
         DP_SQ_MUL: begin
            prod_in = mul_a * mul_b;
            acc_in  = (cmd.comp == 2'd0) ? '0 : total;
         end
         DP_SQ_LAST: begin
            sum_in = total;
            rad_in = is_face_ff ? (RAD_W'(total) << FACE_SHIFT)
                                : (RAD_W'(total) << VERT_SHIFT);
            res_in = '0;
            bit_in = RAD_W'(1) << (RAD_W - 2);
         end
         DP_ZERO_NORM: begin
            nrm_in.x = '0;
            nrm_in.y = UNIT_ONE;
            nrm_in.z = '0;
         end
         DP_ROOT_STEP: begin
            if (rad_ff >= trial) begin
               rad_in = rad_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         DP_DIV_PRE: begin
            num_in = (is_face_ff ? (mag_w << (FACE_SHIFT / 2 + NORMAL_FRAC_BITS))
                                 : (mag_w << (VERT_SHIFT / 2 + NORMAL_FRAC_BITS)))
                     + DIV_W'(res_ff[ROOT_W-1:1]);
            den_in = DIV_W'(res_ff[ROOT_W-1:0]) << DIV_STEPS;
            q_in   = '0;
         end
         DP_DIV_CHK: begin
            sat_in = (num_ff >= den_ff);
            den_in = den_ff >> 1;
         end
         DP_DIV_STEP: begin
            if (num_ff >= den_ff) begin
               num_in = num_ff - den_ff;
               q_in   = {q_ff[DIV_STEPS-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[DIV_STEPS-2:0], 1'b0};
            end
            den_in = den_ff >> 1;
         end
         DP_DIV_END: begin
            qv = q_ff;
            if (sat_ff || (16'(q_ff) > UNIT_ONE)) begin
               qmag = UNIT_ONE;
            end else begin
               qmag = 16'(qv);
            end
            case (cmd.comp)
               2'd0:    nrm_in.x = cv[CMP_W-1] ? -qmag : qmag;
               2'd1:    nrm_in.y = cv[CMP_W-1] ? -qmag : qmag;
               default: nrm_in.z = cv[CMP_W-1] ? -qmag : qmag;
            endcase
         end
         DP_EMIT: begin
            out_in = nrm_ff;
            case (cmd.phase)
               PH_VERT1: begin
                  out_col_in  = col_m1[9:0];
                  out_row_in  = row_m1[9:0];
                  out_last_in = (col_ff != w_m1);
                  out_done_in = 1'b0;
               end
               PH_VERT2: begin
                  out_col_in  = w_m1[9:0];
                  out_row_in  = row_m1[9:0];
                  out_last_in = 1'b1;
                  out_done_in = 1'b0;
               end
               default: begin
                  out_col_in  = flush_ff[9:0];
                  out_row_in  = h_m1[9:0];
                  out_last_in = 1'b1;
                  out_done_in = (flush_ff == w_m1);
               end
            endcase
         end
         DP_ADVANCE: begin
            if (status.has_face) begin
               left1_in = above_ff;
               left0_in = cur_ff;
            end
            if (col_ff + POS_W'(1) >= eff_w) begin
               col_in = '0;
               row_in = row_ff + POS_W'(1);
            end else begin
               col_in = col_ff + POS_W'(1);
            end
            if (row_in >= eff_h) begin
               flush_in = '0;
            end
         end
         DP_FL_ADV: begin
            if (flush_ff == w_m1) begin
               col_in   = '0;
               row_in   = '0;
               flush_in = '0;
            end else begin
               flush_in = flush_ff + POS_W'(1);
            end
         end
         default: begin
         end
      endcase

      // csr writes must arrive only while idle; the block itself does not enforce this
      if (cfg_we) begin
         case (cfg_idx)
            REG_HEIGHT_GAIN: gain_in = cfg_data[15:0];
            REG_GRID_WIDTH: begin
               width_in = cfg_data[10:0];
               col_in   = '0;
               row_in   = '0;
               flush_in = '0;
            end
            REG_GRID_HEIGHT: begin
               height_in = cfg_data[10:0];
               col_in    = '0;
               row_in    = '0;
               flush_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (rd_idx)
         REG_HEIGHT_GAIN: rd_data = {16'h0000, gain_ff};
         REG_GRID_WIDTH:  rd_data = {21'h0, width_ff};
         REG_GRID_HEIGHT: rd_data = {21'h0, height_ff};
         default:         rd_data = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         flush_ff  <= '0;
         left0_ff  <= '0;
         left1_ff  <= '0;
      end else begin
         gain_ff   <= gain_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         flush_ff  <= flush_in;
         left0_ff  <= left0_in;
         left1_ff  <= left1_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      raw_ff      <= raw_in;
      prod_ff     <= prod_in;
      prev_h_ff   <= prev_h_in;
      bl_ff       <= bl_in;
      br_ff       <= br_in;
      ul_ff       <= ul_in;
      vec_ff      <= vec_in;
      is_face_ff  <= is_face_in;
      acc_ff      <= acc_in;
      sum_ff      <= sum_in;
      rad_ff      <= rad_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      q_ff        <= q_in;
      sat_ff      <= sat_in;
      nrm_ff      <= nrm_in;
      cur_ff      <= cur_in;
      above_ff    <= above_in;
      out_ff      <= out_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   assign normal_x    = out_ff.x;
   assign normal_y    = out_ff.y;
   assign normal_z    = out_ff.z;
   assign vertex_col  = out_col_ff;
   assign vertex_row  = out_row_ff;
   assign last_of_run = out_last_ff;
   assign frame_done  = out_done_ff;

endmodule

// ===== sv/hvn_ctrl.sv =====
module hvn_ctrl
   import hvn_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [1:0]         comp_ff, comp_in;
   phase_type          phase_ff, phase_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         comp_ff      <= '0;
         phase_ff     <= PH_FACE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         comp_ff      <= comp_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      comp_in      = comp_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = DP_NONE;
      cmd.comp     = comp_ff;
      cmd.phase    = phase_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_flush) begin
               state_in = status.flush_ok ? ST_FL_RD0 : ST_IDLE;
            end else begin
               state_in = status.sample_ok ? ST_SCALE_MUL : ST_IDLE;
            end
         end
         ST_SCALE_MUL: begin
            cmd.op   = DP_SCALE_MUL;
            state_in = ST_SCALE_WR;
         end
         ST_SCALE_WR: begin
            cmd.op   = DP_SCALE_WR;
            state_in = status.has_face ? ST_FACE_SET : ST_ADVANCE;
         end
         ST_FACE_SET: begin
            cmd.op   = DP_FACE_SET;
            phase_in = PH_FACE;
            count_in = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.op   = DP_SQ_MUL;
            cmd.comp = count_ff[1:0];
            count_in = count_ff + COUNT_W'(1);
            if (count_ff == COUNT_W'(2)) begin
               state_in = ST_SQ_LAST;
            end
         end
         ST_SQ_LAST: begin
            cmd.op   = DP_SQ_LAST;
            state_in = ST_SUM_CHK;
         end
         ST_SUM_CHK: begin
            count_in = '0;
            if (status.sum_zero) begin
               cmd.op   = DP_ZERO_NORM;
               state_in = ST_NORM_DONE;
            end else begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.op   = DP_ROOT_STEP;
            count_in = count_ff + COUNT_W'(1);
            if (count_ff == COUNT_W'(ROOT_STEPS - 1)) begin
               comp_in  = 2'd0;
               state_in = ST_DIV_PRE;
            end
         end
         ST_DIV_PRE: begin
            cmd.op   = DP_DIV_PRE;
            state_in = ST_DIV_CHK;
         end
         ST_DIV_CHK: begin
            cmd.op   = DP_DIV_CHK;
            count_in = '0;
            state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.op   = DP_DIV_STEP;
            count_in = count_ff + COUNT_W'(1);
            if (count_ff == COUNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            cmd.op = DP_DIV_END;
            if (comp_ff == 2'd2) begin
               state_in = ST_NORM_DONE;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_DIV_PRE;
            end
         end
         ST_NORM_DONE: begin
            state_in = (phase_ff == PH_FACE) ? ST_VSUM1 : ST_EMIT;
         end
         ST_VSUM1: begin
            cmd.op   = DP_VSUM1;
            phase_in = PH_VERT1;
            count_in = '0;
            state_in = ST_SQ;
         end
         ST_VSUM2: begin
            cmd.op   = DP_VSUM2;
            phase_in = PH_VERT2;
            count_in = '0;
            state_in = ST_SQ;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = DP_EMIT;
               rsp_valid_in = 1'b1;
               case (phase_ff)
                  PH_VERT1: state_in = status.row_end ? ST_VSUM2 : ST_ADVANCE;
                  PH_VERT2: state_in = ST_ADVANCE;
                  PH_FLUSH: state_in = ST_FL_ADV;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADVANCE: begin
            cmd.op   = DP_ADVANCE;
            state_in = ST_IDLE;
         end
         ST_FL_RD0: begin
            cmd.op   = DP_FL_RD0;
            state_in = ST_FL_RD1;
         end
         ST_FL_RD1: begin
            cmd.op   = DP_FL_RD1;
            state_in = ST_FL_SUM;
         end
         ST_FL_SUM: begin
            cmd.op   = DP_FL_SUM;
            phase_in = PH_FLUSH;
            count_in = '0;
            state_in = ST_SQ;
         end
         ST_FL_ADV: begin
            cmd.op   = DP_FL_ADV;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   // result register is never overwritten while it still holds a result
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_EMIT) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_EMIT) |=> rsp_valid_ff)
      else $error("emitted result not presented");

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (count_ff < COUNT_W'(ROOT_STEPS)))
      else $error("root iteration overrun");

   a_new_req_only_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_LOAD) |=> (state_ff == ST_DECODE))
      else $error("request load did not start decode");

endmodule

// ===== sv/heightmap_vertex_normals.sv =====
// Channel  | Ports                                  | Moves
// ---------+----------------------------------------+------------------------------
// request  | req_valid/req_ready, req_op, req_height | height sample or flush tick
// response | rsp_valid/rsp_ready, rsp_normal_*, ...  | one vertex normal per result
// csr      | psel/penable/pwrite/paddr/pwdata/...    | height_gain, grid_width/height
//
// One request at a time. A sample that closes a quad runs a face and a vertex
// normalisation, and a second vertex normalisation at row end. A flush tick runs
// one vertex normalisation. Each normalisation runs 3 squares on the shared
// multiplier, 30 root steps and the divide steps on one shift/subtract unit.
// Reset is synchronous; the height and face row memories are not cleared.
// A waiting result does not block the next request; a second result stalls
// the sequencer until the result register frees.
module heightmap_vertex_normals
   import hvn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [15:0]        req_height,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic [9:0]         rsp_vertex_col,
   output logic [9:0]         rsp_vertex_row,
   output logic               rsp_last_of_run,
   output logic               rsp_frame_done,

   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          cfg_we;

   // registers sit on word addresses; write lands on the access phase
   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite;

   hvn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hvn_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_op      (req_op),
      .req_height  (req_height),
      .cfg_we      (cfg_we),
      .cfg_idx     (paddr[CSR_AW-1:2]),
      .cfg_data    (pwdata),
      .rd_idx      (paddr[CSR_AW-1:2]),
      .rd_data     (prdata),
      .cmd         (cmd),
      .status      (status),
      .normal_x    (rsp_normal_x),
      .normal_y    (rsp_normal_y),
      .normal_z    (rsp_normal_z),
      .vertex_col  (rsp_vertex_col),
      .vertex_row  (rsp_vertex_row),
      .last_of_run (rsp_last_of_run),
      .frame_done  (rsp_frame_done)
   );

endmodule
